### src/psev_pkg.sv
// Shared types and constants for the postfix stack evaluator.
`timescale 1ns / 1ps

package psev_pkg;

  localparam int DATA_W      = 32;
  localparam int DEPTH_OUT_W = 6;

  typedef logic [2:0] op_t;
  typedef logic [1:0] status_t;

  localparam op_t OP_PUSH = 3'd0;
  localparam op_t OP_ADD  = 3'd1;
  localparam op_t OP_SUB  = 3'd2;
  localparam op_t OP_MUL  = 3'd3;
  localparam op_t OP_DIV  = 3'd4;

  localparam status_t ST_OK    = 2'd0;
  localparam status_t ST_UNDER = 2'd1;
  localparam status_t ST_OVER  = 2'd2;
  localparam status_t ST_DIVZ  = 2'd3;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic    take;       // latch the value of an accepted item
    logic    push;       // write value on top, count up
    logic    rd;         // read the entry below the top
    logic    alu;        // compute add, subtract or multiply into res
    op_t     alu_op;
    logic    div_start;  // start the divider on lhs and top
    logic    commit;     // write the result below the top, count down
    logic    from_div;   // commit takes the quotient instead of res
    logic    load_out;   // load the result registers
    logic    last;       // item ends the expression
    status_t st;         // fault found while executing the item
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic empty;
    logic full;
    logic lt2;
    logic rhs_zero;
    logic div_done;
  } sts_t;

endpackage

### src/psev_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module psev_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and read; read data holds until the next read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### src/psev_div.sv
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
`timescale 1ns / 1ps

module psev_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [psev_pkg::DATA_W-1:0] a,
  input  logic [psev_pkg::DATA_W-1:0] b,
  output logic [psev_pkg::DATA_W-1:0] q,
  output logic                        done
);

  localparam int W  = psev_pkg::DATA_W;
  localparam int NW = $clog2(W);

  logic          busy;
  logic [NW-1:0] cnt;
  logic          neg;
  logic [W-1:0]  rem;
  logic [W-1:0]  quo;
  logic [W-1:0]  mb;
  logic [W:0]    shifted;
  logic          fits;
  logic [W-1:0]  quo_step;

  // One restoring step
  always_comb begin
    shifted  = {rem, quo[W-1]};
    fits     = shifted >= {1'b0, mb};
    quo_step = {quo[W-2:0], fits};
  end

  // Sequence the division, one restoring step per quotient bit
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        neg  <= a[W-1] ^ b[W-1];
        rem  <= '0;
        quo  <= a[W-1] ? (W'(0) - a) : a;
        mb   <= b[W-1] ? (W'(0) - b) : b;
      end else if (busy) begin
        rem <= fits ? W'(shifted - {1'b0, mb}) : shifted[W-1:0];
        quo <= quo_step;
        cnt <= cnt + NW'(1);
        if (cnt == NW'(W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
          q    <= neg ? (W'(0) - quo_step) : quo_step;
        end
      end
    end
  end

  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("divider done without a running division");

endmodule

### src/psev_dp.sv
// Datapath: operand stack RAM, cached top entry, count, ALU and result registers.
`timescale 1ns / 1ps

module psev_dp #(
  parameter int STACK_DEPTH = 32
) (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic [psev_pkg::DATA_W-1:0]              value,
  input  psev_pkg::cmd_t                           cmd,
  output psev_pkg::sts_t                           sts,
  output logic signed [psev_pkg::DATA_W-1:0]       top_value,
  output logic [psev_pkg::DEPTH_OUT_W-1:0]         stack_depth,
  output psev_pkg::status_t                        status,
  output logic                                     is_final
);

  localparam int W  = psev_pkg::DATA_W;
  localparam int AW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);

  logic [W-1:0]  value_q;
  logic [CW-1:0] count;
  logic [W-1:0]  top;
  logic [W-1:0]  res;
  logic [CW-1:0] below;
  logic          we;
  logic [AW-1:0] waddr;
  logic [W-1:0]  wdata;
  logic [W-1:0]  rdata;
  logic [W-1:0]  commit_data;
  logic [W-1:0]  quot;
  logic          div_done;

  assign below       = count - CW'(2);
  assign commit_data = cmd.from_div ? quot : res;
  assign we          = cmd.push | cmd.commit;
  assign waddr       = cmd.push ? count[AW-1:0] : below[AW-1:0];
  assign wdata       = cmd.push ? value_q : commit_data;

  psev_ram #(
    .WIDTH(W),
    .DEPTH(STACK_DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .re   (cmd.rd),
    .raddr(below[AW-1:0]),
    .rdata(rdata)
  );

  // Left operand comes from the RAM, right operand from the cached top
  psev_div u_div (
    .clk  (clk),
    .rst  (rst),
    .start(cmd.div_start),
    .a    (rdata),
    .b    (top),
    .q    (quot),
    .done (div_done)
  );

  always_comb begin
    sts.empty    = count == CW'(0);
    sts.full     = count == CW'(STACK_DEPTH);
    sts.lt2      = count < CW'(2);
    sts.rhs_zero = top == W'(0);
    sts.div_done = div_done;
  end

  // Hold the count; clear it when the result of a last item is loaded
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.push) begin
      count <= count + CW'(1);
    end else if (cmd.commit) begin
      count <= count - CW'(1);
    end else if (cmd.load_out && cmd.last) begin
      count <= '0;
    end
  end

  // Latch the item, update the top, compute, load the result
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      value_q <= value;
    end
    if (cmd.push) begin
      top <= value_q;
    end else if (cmd.commit) begin
      top <= commit_data;
    end
    if (cmd.alu) begin
      case (cmd.alu_op)
        psev_pkg::OP_ADD: res <= rdata + top;
        psev_pkg::OP_SUB: res <= rdata - top;
        default:          res <= rdata * top;
      endcase
    end
    if (cmd.load_out) begin
      if (cmd.last) begin
        stack_depth <= '0;
        if (sts.empty) begin
          top_value <= '0;
          is_final  <= 1'b0;
          status    <= (cmd.st == psev_pkg::ST_OK) ? psev_pkg::ST_UNDER : cmd.st;
        end else begin
          top_value <= top;
          is_final  <= 1'b1;
          status    <= cmd.st;
        end
      end else begin
        top_value   <= sts.empty ? '0 : top;
        stack_depth <= psev_pkg::DEPTH_OUT_W'(count);
        is_final    <= 1'b0;
        status      <= cmd.st;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(STACK_DEPTH))
    else $error("stack count beyond depth");

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    cmd.push |-> !sts.full)
    else $error("push on a full stack");

  a_no_commit_low: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> !sts.lt2)
    else $error("commit with fewer than two entries");

endmodule

### src/psev_ctrl.sv
// Controller: sequences each token through decode, operand read, compute and result.
`timescale 1ns / 1ps

module psev_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                token_valid,
  output logic                token_stall,
  input  psev_pkg::op_t       op,
  input  logic                end_of_expression,
  output logic                result_valid,
  input  logic                result_stall,
  input  psev_pkg::sts_t      sts,
  output psev_pkg::cmd_t      cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_EXEC,
    S_DIV,
    S_WRITE,
    S_FINISH
  } state_t;

  state_t            state;
  state_t            state_next;
  psev_pkg::op_t     op_q;
  logic              last_q;
  psev_pkg::status_t st_q;
  psev_pkg::status_t st_next;
  logic              accept;
  logic              slot_free;

  assign token_stall = state != S_IDLE;
  assign accept      = token_valid && !token_stall;
  assign slot_free   = !result_valid || !result_stall;

  // Decode state into commands
  always_comb begin
    cmd        = '0;
    cmd.alu_op = op_q;
    cmd.last   = last_q;
    cmd.st     = st_q;
    cmd.take   = accept;
    state_next = state;
    st_next    = st_q;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = S_DECODE;
          st_next    = psev_pkg::ST_OK;
        end
      end
      S_DECODE: begin
        state_next = S_FINISH;
        unique case (op_q) inside
          psev_pkg::OP_PUSH: begin
            if (sts.full) begin
              st_next = psev_pkg::ST_OVER;
            end else begin
              cmd.push = 1'b1;
            end
          end
          psev_pkg::OP_ADD, psev_pkg::OP_SUB, psev_pkg::OP_MUL, psev_pkg::OP_DIV: begin
            if (sts.lt2) begin
              st_next = psev_pkg::ST_UNDER;
            end else if (op_q == psev_pkg::OP_DIV && sts.rhs_zero) begin
              st_next = psev_pkg::ST_DIVZ;
            end else begin
              cmd.rd     = 1'b1;
              state_next = S_EXEC;
            end
          end
          default: begin
            state_next = S_FINISH;
          end
        endcase
      end
      S_EXEC: begin
        if (op_q == psev_pkg::OP_DIV) begin
          cmd.div_start = 1'b1;
          state_next    = S_DIV;
        end else begin
          cmd.alu    = 1'b1;
          state_next = S_WRITE;
        end
      end
      S_DIV: begin
        if (sts.div_done) begin
          cmd.commit   = 1'b1;
          cmd.from_div = 1'b1;
          state_next   = S_FINISH;
        end
      end
      S_WRITE: begin
        cmd.commit = 1'b1;
        state_next = S_FINISH;
      end
      S_FINISH: begin
        if (slot_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Hold state, the item's control fields and the result valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      st_q         <= psev_pkg::ST_OK;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      st_q  <= st_next;
      if (accept) begin
        op_q   <= op;
        last_q <= end_of_expression;
      end
      if (cmd.load_out) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  a_load_slot_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> slot_free)
    else $error("result loaded over an untaken result");

  a_one_item_at_time: assert property (@(posedge clk) disable iff (rst)
    accept |=> token_stall)
    else $error("second item accepted while one is at work");

endmodule

### src/postfix_stack_evaluator_unit.sv
// Top level of the postfix stack evaluator: controller plus datapath.
`timescale 1ns / 1ps
//
// Evaluates postfix tokens on a signed 32-bit operand stack.
// Token channel: token_valid / token_stall with op, value, end_of_expression.
// Result channel: result_valid / result_stall with top_value, stack_depth,
// status and is_final; exactly one result per token.
// One token is at work at a time; token_stall is low only while idle, and
// a new token may enter while the previous result still waits.
// A push, an ignored code or any faulted token is handled in decode and
// then moves to the final step that loads the result; add, subtract and
// multiply read the entry below the top from the RAM, then run the ALU,
// then write back; divide reads the RAM, then runs the iterative divider
// at one quotient bit a cycle over all 32 bits, then writes the quotient.
// No new token is taken until the previous one has loaded its result.
// Reset (rst, synchronous) empties the stack and drops any pending result;
// stack contents are not cleared, only entries below the count are read.
// When the receiver stalls, the result is held and the next token waits in
// its final step until the result register is free.
//

module postfix_stack_evaluator_unit #(
  parameter int STACK_DEPTH = 32
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   token_valid,
  output logic                                   token_stall,
  input  logic [2:0]                             op,
  input  logic signed [psev_pkg::DATA_W-1:0]     value,
  input  logic                                   end_of_expression,
  output logic                                   result_valid,
  input  logic                                   result_stall,
  output logic signed [psev_pkg::DATA_W-1:0]     top_value,
  output logic [psev_pkg::DEPTH_OUT_W-1:0]       stack_depth,
  output logic [1:0]                             status,
  output logic                                   is_final
);

  psev_pkg::cmd_t cmd;
  psev_pkg::sts_t sts;

  psev_ctrl u_ctrl (
    .clk              (clk),
    .rst              (rst),
    .token_valid      (token_valid),
    .token_stall      (token_stall),
    .op               (op),
    .end_of_expression(end_of_expression),
    .result_valid     (result_valid),
    .result_stall     (result_stall),
    .sts              (sts),
    .cmd              (cmd)
  );

  psev_dp #(
    .STACK_DEPTH(STACK_DEPTH)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .value      (value),
    .cmd        (cmd),
    .sts        (sts),
    .top_value  (top_value),
    .stack_depth(stack_depth),
    .status     (status),
    .is_final   (is_final)
  );

endmodule
